/* rtl/h264_rtp_packetizer_unit_macros.svh */
// Assertion macros shared by the packetizer RTL.
// Relies on clk and arst_n being visible in the module that uses them.
`ifndef H264_RTP_PACKETIZER_UNIT_MACROS_SVH
`define H264_RTP_PACKETIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define H264RTP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define H264RTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/h264rtp_pkg.sv */
// Shared types and constants for the H.264 RTP packetizer.
// No dependencies; used by every module of the block.
package h264rtp_pkg;

	localparam int ADDR_BITS = 4;

	typedef enum logic [1:0] {
		REG_SSRC        = 2'd0,
		REG_TS_STEP     = 2'd1,
		REG_MAX_PAYLOAD = 2'd2,
		REG_PAYLOAD_TYPE = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] TS_STEP_RESET     = 16'd3600;
	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1400;
	localparam logic [6:0]  PT_RESET          = 7'd96;
	localparam logic [15:0] SEQ_RESET         = 16'd1;

	localparam logic [7:0] RTP_VER_BYTE = 8'h80;
	localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
	localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
	localparam logic [4:0] NAL_TYPE_FUA = 5'd28;

	// Byte positions within one run of output bytes
	typedef enum logic [3:0] {
		POS_VER     = 4'd0,
		POS_PT      = 4'd1,
		POS_SEQ_HI  = 4'd2,
		POS_SEQ_LO  = 4'd3,
		POS_TS_3    = 4'd4,
		POS_TS_2    = 4'd5,
		POS_TS_1    = 4'd6,
		POS_TS_0    = 4'd7,
		POS_SSRC_3  = 4'd8,
		POS_SSRC_2  = 4'd9,
		POS_SSRC_1  = 4'd10,
		POS_SSRC_0  = 4'd11,
		POS_FU_IND  = 4'd12,
		POS_FU_HDR  = 4'd13,
		POS_PAYLOAD = 4'd14
	} pos_t;

	// What one input transaction puts out: optional RTP header, optional
	// FU-A bytes, then always the payload byte.
	typedef struct packed {
		logic        has_hdr;
		logic        has_fu;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [7:0]  fu_ind;
		logic [7:0]  fu_hdr;
		logic [7:0]  pay_byte;
		logic        pay_last;
	} desc_t;

endpackage

/* rtl/h264rtp_cfg.sv */
// APB register file for the packetizer: ssrc, timestamp step, max payload, payload type.
// Depends on h264rtp_pkg.
module h264rtp_cfg #(
	parameter int PAYLOAD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [h264rtp_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output logic [31:0]                       ssrc,
	output logic [15:0]                       ts_step,
	output logic [PAYLOAD_BITS-1:0]           max_payload,
	output logic [6:0]                        payload_type
);

	logic [31:0]             ssrc_q;
	logic [15:0]             ts_step_q;
	logic [PAYLOAD_BITS-1:0] max_payload_q;
	logic [6:0]              payload_type_q;
	logic                    wr_en;
	h264rtp_pkg::cfg_reg_t   reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = h264rtp_pkg::cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssrc_q         <= '0;
			ts_step_q      <= h264rtp_pkg::TS_STEP_RESET;
			max_payload_q  <= h264rtp_pkg::MAX_PAYLOAD_RESET[PAYLOAD_BITS-1:0];
			payload_type_q <= h264rtp_pkg::PT_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				h264rtp_pkg::REG_SSRC:         ssrc_q         <= pwdata;
				h264rtp_pkg::REG_TS_STEP:      ts_step_q      <= pwdata[15:0];
				h264rtp_pkg::REG_MAX_PAYLOAD:  max_payload_q  <= pwdata[PAYLOAD_BITS-1:0];
				h264rtp_pkg::REG_PAYLOAD_TYPE: payload_type_q <= pwdata[6:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			h264rtp_pkg::REG_SSRC:         prdata = ssrc_q;
			h264rtp_pkg::REG_TS_STEP:      prdata = {16'd0, ts_step_q};
			h264rtp_pkg::REG_MAX_PAYLOAD:  prdata = 32'(max_payload_q);
			h264rtp_pkg::REG_PAYLOAD_TYPE: prdata = {25'd0, payload_type_q};
		endcase
	end

	assign ssrc         = ssrc_q;
	assign ts_step      = ts_step_q;
	assign max_payload  = max_payload_q;
	assign payload_type = payload_type_q;

endmodule

/* rtl/h264rtp_core.sv */
// Packetizer state: sequence, timestamp, NAL header and fragment tracking.
// Builds at most one output descriptor per input transaction. Depends on h264rtp_pkg.
`include "h264_rtp_packetizer_unit_macros.svh"

module h264rtp_core #(
	parameter int NAL_LENGTH_BITS = 20,
	parameter int PAYLOAD_BITS    = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [7:0]                 nal_byte,
	input  logic                       nal_first,
	input  logic [NAL_LENGTH_BITS-1:0] nal_length,
	input  logic [15:0]                ts_step,
	input  logic [PAYLOAD_BITS-1:0]    max_payload,
	output logic                       emit,
	output h264rtp_pkg::desc_t         desc
);

	localparam int LW = NAL_LENGTH_BITS;
	localparam int PB = PAYLOAD_BITS;
	localparam int CW = (LW > PB) ? LW : PB;

	logic [15:0]   seq_q, seq_d;
	logic [31:0]   ts_q, ts_d;
	logic [7:0]    saved_q, saved_d;
	logic [LW-1:0] left_q, left_d;
	logic [PB-1:0] fpos_q, fpos_d;
	logic          fmode_q, fmode_d;
	logic          ffp_q, ffp_d;

	logic [PB-1:0] mp;
	logic [CW-1:0] mp_c;
	logic [LW-1:0] len;
	logic [LW-1:0] left_dec;
	logic [PB-1:0] fpos_inc;
	logic          frag_end;

	assign mp       = (max_payload == '0) ? PB'(1) : max_payload;
	assign mp_c     = CW'(mp);
	assign len      = (nal_length == '0) ? LW'(1) : nal_length;
	assign left_dec = left_q - LW'(1);
	assign fpos_inc = fpos_q + PB'(1);
	assign frag_end = (left_dec == '0) || (fpos_inc >= mp);

	always_comb begin
		seq_d   = seq_q;
		ts_d    = ts_q;
		saved_d = saved_q;
		left_d  = left_q;
		fpos_d  = fpos_q;
		fmode_d = fmode_q;
		ffp_d   = ffp_q;
		emit    = 1'b0;

		desc          = '0;
		desc.seq      = seq_q;
		desc.ts       = ts_q;
		desc.pay_byte = nal_byte;
		desc.fu_ind   = {1'b0, saved_q[6:5], h264rtp_pkg::NAL_TYPE_FUA};
		desc.fu_hdr   = {ffp_q, (CW'(left_q) <= mp_c), 1'b0, saved_q[4:0]};

		if (nal_first) begin
			// SPS and PPS keep the current timestamp and do not advance it
			if (nal_byte[4:0] != h264rtp_pkg::NAL_TYPE_SPS &&
					nal_byte[4:0] != h264rtp_pkg::NAL_TYPE_PPS) begin
				ts_d = ts_q + {16'd0, ts_step};
			end
			saved_d = nal_byte;
			left_d  = len - LW'(1);
			fpos_d  = '0;
			if (CW'(len) <= mp_c) begin
				fmode_d       = 1'b0;
				ffp_d         = 1'b0;
				emit          = 1'b1;
				desc.has_hdr  = 1'b1;
				desc.ts       = ts_d;
				desc.pay_last = (len == LW'(1));
				seq_d         = seq_q + 16'd1;
			end else begin
				// header byte is dropped; the FU-A bytes carry its fields
				fmode_d = 1'b1;
				ffp_d   = 1'b1;
			end
		end else if (left_q != '0) begin
			emit   = 1'b1;
			left_d = left_dec;
			if (!fmode_q) begin
				desc.pay_last = (left_dec == '0);
			end else begin
				if (fpos_q == '0) begin
					desc.has_hdr = 1'b1;
					desc.has_fu  = 1'b1;
					ffp_d        = 1'b0;
					seq_d        = seq_q + 16'd1;
				end
				desc.pay_last = frag_end;
				fpos_d        = frag_end ? '0 : fpos_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= h264rtp_pkg::SEQ_RESET;
			ts_q    <= '0;
			saved_q <= '0;
			left_q  <= '0;
			fpos_q  <= '0;
			fmode_q <= 1'b0;
			ffp_q   <= 1'b0;
		end else if (accept) begin
			seq_q   <= seq_d;
			ts_q    <= ts_d;
			saved_q <= saved_d;
			left_q  <= left_d;
			fpos_q  <= fpos_d;
			fmode_q <= fmode_d;
			ffp_q   <= ffp_d;
		end
	end

	`H264RTP_ASSERT_NEXT(a_seq_hold, accept && !(emit && desc.has_hdr), $stable(seq_q),
		"sequence number moved without a header")
	`H264RTP_ASSERT_NOW(a_ffp_mode, !fmode_q, !ffp_q,
		"first-fragment flag set outside fragment mode")
	`H264RTP_ASSERT_NOW(a_fu_has_hdr, emit && desc.has_fu, desc.has_hdr && fmode_q,
		"FU bytes without an RTP header")

endmodule

/* rtl/h264rtp_ser.sv */
// Output register and byte serializer: walks one descriptor out a byte per transaction.
// Depends on h264rtp_pkg.
`include "h264_rtp_packetizer_unit_macros.svh"

module h264rtp_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  h264rtp_pkg::desc_t desc,
	input  logic [31:0]        ssrc,
	input  logic [6:0]         payload_type,
	output logic               free,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               packet_first,
	output logic               packet_last,
	output logic               run_last
);

	h264rtp_pkg::desc_t desc_s1;
	h264rtp_pkg::pos_t  pos_q;
	logic               valid_q;
	logic               out_acc;
	logic               at_pay;

	assign at_pay  = (pos_q == h264rtp_pkg::POS_PAYLOAD);
	assign out_acc = valid_q && out_ready;
	// a new descriptor may enter as the payload byte of the current one leaves
	assign free    = !valid_q || (out_ready && at_pay);

	always_ff @(posedge clk) begin
		if (load) begin
			desc_s1 <= desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= h264rtp_pkg::POS_VER;
		end else if (load) begin
			valid_q <= 1'b1;
			pos_q   <= desc.has_hdr ? h264rtp_pkg::POS_VER : h264rtp_pkg::POS_PAYLOAD;
		end else if (out_acc) begin
			if (at_pay) begin
				valid_q <= 1'b0;
			end else if (pos_q == h264rtp_pkg::POS_SSRC_0 && !desc_s1.has_fu) begin
				pos_q <= h264rtp_pkg::POS_PAYLOAD;
			end else begin
				pos_q <= h264rtp_pkg::pos_t'(pos_q + 4'd1);
			end
		end
	end

	always_comb begin
		case (pos_q)
			h264rtp_pkg::POS_VER:     out_byte = h264rtp_pkg::RTP_VER_BYTE;
			h264rtp_pkg::POS_PT:      out_byte = {1'b0, payload_type};
			h264rtp_pkg::POS_SEQ_HI:  out_byte = desc_s1.seq[15:8];
			h264rtp_pkg::POS_SEQ_LO:  out_byte = desc_s1.seq[7:0];
			h264rtp_pkg::POS_TS_3:    out_byte = desc_s1.ts[31:24];
			h264rtp_pkg::POS_TS_2:    out_byte = desc_s1.ts[23:16];
			h264rtp_pkg::POS_TS_1:    out_byte = desc_s1.ts[15:8];
			h264rtp_pkg::POS_TS_0:    out_byte = desc_s1.ts[7:0];
			h264rtp_pkg::POS_SSRC_3:  out_byte = ssrc[31:24];
			h264rtp_pkg::POS_SSRC_2:  out_byte = ssrc[23:16];
			h264rtp_pkg::POS_SSRC_1:  out_byte = ssrc[15:8];
			h264rtp_pkg::POS_SSRC_0:  out_byte = ssrc[7:0];
			h264rtp_pkg::POS_FU_IND:  out_byte = desc_s1.fu_ind;
			h264rtp_pkg::POS_FU_HDR:  out_byte = desc_s1.fu_hdr;
			h264rtp_pkg::POS_PAYLOAD: out_byte = desc_s1.pay_byte;
			default:                  out_byte = desc_s1.pay_byte;
		endcase
	end

	assign out_valid    = valid_q;
	assign packet_first = (pos_q == h264rtp_pkg::POS_VER);
	assign packet_last  = at_pay && desc_s1.pay_last;
	assign run_last     = at_pay;

	`H264RTP_ASSERT_NOW(a_free_busy, valid_q && free, at_pay,
		"input side opened before the payload byte")
	`H264RTP_ASSERT_NEXT(a_run_gapless, out_acc && !at_pay, valid_q,
		"gap inside a run of output bytes")
	`H264RTP_ASSERT_NOW(a_last_in_run, valid_q && packet_last, run_last,
		"packet end away from the payload byte")

endmodule

/* rtl/h264_rtp_packetizer_unit.sv */
// H.264 RTP packetizer: top level joining registers, packet state and serializer.
// Depends on h264rtp_pkg, h264rtp_cfg, h264rtp_core and h264rtp_ser.
//
// Input channel (in_valid/in_ready) takes one NAL byte per transaction;
// nal_first marks the NAL header byte and nal_length is sampled with it.
// Output channel (out_valid/out_ready) gives one RTP packet byte per
// transaction, with packet_first/packet_last framing and run_last on the
// final byte produced by each input byte.
// An input byte yields 0, 1, 13 (new single-NAL packet) or 15 (new FU-A
// fragment) output bytes. The header byte of a fragmented NAL yields none.
// The first output byte is valid in the cycle after the input transaction.
// Throughput: payload bytes run at one per cycle while out_ready is high;
// an item that opens a packet holds the input while the one-byte output
// serializer sends its header bytes, and the next input is taken as its last byte leaves.
// Reset clears sequence (to 1), timestamp and fragment state and loads the
// register defaults. A stalled receiver holds the current byte and, once the
// output register is full, stalls the input side.
// Registers sit on APB at 0x0 ssrc, 0x4 timestamp step, 0x8 max payload,
// 0xC payload type; pready is always high.
module h264_rtp_packetizer_unit #(
	parameter int NAL_LENGTH_BITS = 20,
	parameter int PAYLOAD_BITS    = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [h264rtp_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        nal_byte,
	input  logic                              nal_first,
	input  logic [NAL_LENGTH_BITS-1:0]        nal_length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_byte,
	output logic                              packet_first,
	output logic                              packet_last,
	output logic                              run_last
);

	logic [31:0]             ssrc;
	logic [15:0]             ts_step;
	logic [PAYLOAD_BITS-1:0] max_payload;
	logic [6:0]              payload_type;
	logic                    accept;
	logic                    emit;
	logic                    free;
	h264rtp_pkg::desc_t      desc;

	assign in_ready = free;
	assign accept   = in_valid && free;

	h264rtp_cfg #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.ssrc        (ssrc),
		.ts_step     (ts_step),
		.max_payload (max_payload),
		.payload_type(payload_type)
	);

	h264rtp_core #(
		.NAL_LENGTH_BITS(NAL_LENGTH_BITS),
		.PAYLOAD_BITS   (PAYLOAD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.nal_byte   (nal_byte),
		.nal_first  (nal_first),
		.nal_length (nal_length),
		.ts_step    (ts_step),
		.max_payload(max_payload),
		.emit       (emit),
		.desc       (desc)
	);

	h264rtp_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept && emit),
		.desc        (desc),
		.ssrc        (ssrc),
		.payload_type(payload_type),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.packet_first(packet_first),
		.packet_last (packet_last),
		.run_last    (run_last)
	);

endmodule

/* test/tb.sv */
// Self-checking testbench for h264_rtp_packetizer_unit: NAL bytes in, RTP bytes out.
// Uses h264rtp_pkg for register codes and header constants; a scoreboard class
// predicts single-NAL and FU-A packets, plain tasks drive the APB and byte channels.
module tb;

	localparam int LEN_BITS     = 20;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;
	localparam int RAND_ITEMS   = 160;
	localparam int FLAT_ITEMS   = 20;
	localparam int CYCLE_LIMIT  = 200_000;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       run_end;
	} rtp_byte_t;

	class rtp_scoreboard;
		logic [31:0]   ssrc;
		logic [15:0]   ts_step;
		logic [11:0]   max_pay;
		logic [6:0]    pt;
		logic [15:0]   seq_num;
		logic [31:0]   ts_val;
		logic [7:0]    nal_hdr;
		logic [19:0]   bytes_left;
		logic [11:0]   frag_pos;
		logic          frag_mode;
		logic          frag_start_due;
		rtp_byte_t     expected_q[$];
		int unsigned   errors, checked, packets, fragments, stray;

		function new();
			ssrc           = '0;
			ts_step        = h264rtp_pkg::TS_STEP_RESET;
			max_pay        = h264rtp_pkg::MAX_PAYLOAD_RESET[11:0];
			pt             = h264rtp_pkg::PT_RESET;
			seq_num        = h264rtp_pkg::SEQ_RESET;
			ts_val         = '0;
			nal_hdr        = '0;
			bytes_left     = '0;
			frag_pos       = '0;
			frag_mode      = 1'b0;
			frag_start_due = 1'b0;
		endfunction

		function void write_reg(h264rtp_pkg::cfg_reg_t r, logic [31:0] v);
			case (r)
				h264rtp_pkg::REG_SSRC:         ssrc    = v;
				h264rtp_pkg::REG_TS_STEP:      ts_step = v[15:0];
				h264rtp_pkg::REG_MAX_PAYLOAD:  max_pay = v[11:0];
				h264rtp_pkg::REG_PAYLOAD_TYPE: pt      = v[6:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push_byte(logic [7:0] d, logic f, logic l);
			rtp_byte_t e;
			e = '{data: d, first: f, last: l, run_end: 1'b0};
			expected_q.push_back(e);
		endfunction

		function void push_rtp_header();
			push_byte(h264rtp_pkg::RTP_VER_BYTE, 1'b1, 1'b0);
			push_byte({1'b0, pt}, 1'b0, 1'b0);
			push_byte(seq_num[15:8], 1'b0, 1'b0);
			push_byte(seq_num[7:0], 1'b0, 1'b0);
			push_byte(ts_val[31:24], 1'b0, 1'b0);
			push_byte(ts_val[23:16], 1'b0, 1'b0);
			push_byte(ts_val[15:8], 1'b0, 1'b0);
			push_byte(ts_val[7:0], 1'b0, 1'b0);
			push_byte(ssrc[31:24], 1'b0, 1'b0);
			push_byte(ssrc[23:16], 1'b0, 1'b0);
			push_byte(ssrc[15:8], 1'b0, 1'b0);
			push_byte(ssrc[7:0], 1'b0, 1'b0);
			seq_num = seq_num + 16'd1;
			packets++;
		endfunction

		// Returns 1 when the byte is ignored (nothing open).
		function bit note_input(logic [7:0] b, logic f, logic [LEN_BITS-1:0] len);
			int          n0;
			logic [19:0] nal_len;
			logic [11:0] mp;
			logic [7:0]  fu;
			logic        frag_end;
			n0 = expected_q.size();
			mp = (max_pay == 12'd0) ? 12'd1 : max_pay;
			if (f) begin
				nal_len = (len == '0) ? 20'd1 : len;
				if (b[4:0] != h264rtp_pkg::NAL_TYPE_SPS && b[4:0] != h264rtp_pkg::NAL_TYPE_PPS)
					ts_val = ts_val + {16'd0, ts_step};
				nal_hdr    = b;
				bytes_left = nal_len - 20'd1;
				frag_pos   = '0;
				if (nal_len <= {8'd0, mp}) begin
					frag_mode      = 1'b0;
					frag_start_due = 1'b0;
					push_rtp_header();
					push_byte(b, 1'b0, bytes_left == '0);
				end else begin
					// header byte is dropped; first fragment comes with the next byte
					frag_mode      = 1'b1;
					frag_start_due = 1'b1;
				end
			end else if (bytes_left == '0) begin
				stray++;
				return 1'b1;
			end else if (!frag_mode) begin
				bytes_left = bytes_left - 20'd1;
				push_byte(b, 1'b0, bytes_left == '0);
			end else begin
				if (frag_pos == '0) begin
					fu = {3'b000, nal_hdr[4:0]};
					if (frag_start_due)
						fu[7] = 1'b1;
					if (bytes_left <= {8'd0, mp})
						fu[6] = 1'b1;
					push_rtp_header();
					push_byte({1'b0, nal_hdr[6:5], h264rtp_pkg::NAL_TYPE_FUA}, 1'b0, 1'b0);
					push_byte(fu, 1'b0, 1'b0);
					frag_start_due = 1'b0;
					fragments++;
				end
				bytes_left = bytes_left - 20'd1;
				frag_pos   = frag_pos + 12'd1;
				frag_end   = (bytes_left == '0) || (frag_pos >= mp);
				push_byte(b, 1'b0, frag_end);
				if (frag_end)
					frag_pos = '0;
			end
			if (expected_q.size() > n0)
				expected_q[expected_q.size()-1].run_end = 1'b1;
			return 1'b0;
		endfunction

		function void check_result(logic [7:0] d, logic f, logic l, logic r);
			rtp_byte_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected output byte: expected none, got %02h", $time, d);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (d !== want.data) begin
				errors++;
				$display("%0t: out_byte expected %02h got %02h", $time, want.data, d);
			end
			if (f !== want.first) begin
				errors++;
				$display("%0t: packet_first expected %b got %b", $time, want.first, f);
			end
			if (l !== want.last) begin
				errors++;
				$display("%0t: packet_last expected %b got %b", $time, want.last, l);
			end
			if (r !== want.run_end) begin
				errors++;
				$display("%0t: run_last expected %b got %b", $time, want.run_end, r);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [h264rtp_pkg::ADDR_BITS-1:0] paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid, in_ready;
	logic [7:0]          nal_byte;
	logic                nal_first;
	logic [LEN_BITS-1:0] nal_length;
	logic                out_valid, out_ready;
	logic [7:0]          out_byte;
	logic                packet_first, packet_last, run_last;

	rtp_scoreboard sb;
	bit            tx_idle_en, rx_idle_en, hold_req;
	int unsigned   items_done, cfg_phases, cycles;

	h264_rtp_packetizer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.nal_byte     (nal_byte),
		.nal_first    (nal_first),
		.nal_length   (nal_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.packet_first (packet_first),
		.packet_last  (packet_last),
		.run_last     (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timed out after %0d cycles", cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Receiver: short random stalls, plus one long hold-off on request
	initial begin
		int stall_cnt;
		out_ready = 1'b0;
		stall_cnt = 0;
		forever begin
			@(negedge clk);
			if (stall_cnt > 0) begin
				out_ready = 1'b0;
				stall_cnt--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				out_ready = 1'b0;
				stall_cnt = HOLD_CYCLES - 1;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				stall_cnt = $urandom_range(0, 4);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_byte, packet_first, packet_last, run_last);
	end

	// Called at a falling edge; returns at the falling edge after acceptance,
	// leaving in_valid high so a following item keeps it high.
	task automatic send_byte(input logic [7:0] b, input logic f, input logic [LEN_BITS-1:0] len);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid   = 1'b1;
		nal_byte   = b;
		nal_first  = f;
		nal_length = len;
		do @(posedge clk); while (!in_ready);
		if (!sb.note_input(b, f, len))
			items_done++;
		@(negedge clk);
	endtask

	task automatic send_nal(input logic [7:0] hdr, input logic [LEN_BITS-1:0] len, input int body);
		send_byte(hdr, 1'b1, len);
		repeat (body)
			send_byte(8'($urandom_range(0, 255)), 1'b0,
				LEN_BITS'($urandom_range(0, 20'hFFFFF)));
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input h264rtp_pkg::cfg_reg_t r, input logic [31:0] v);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {r, 2'b00};
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		sb.write_reg(r, v);
	endtask

	task automatic random_config();
		logic [31:0] mp;
		logic [31:0] step;
		case ($urandom_range(0, 7))
			0:       mp = 0;
			1:       mp = 4095;
			2:       mp = $urandom_range(13, 64);
			default: mp = $urandom_range(1, 12);
		endcase
		case ($urandom_range(0, 3))
			0:       step = 0;
			1:       step = 32'hFFFF;
			default: step = $urandom_range(0, 16'hFFFF);
		endcase
		reg_write(h264rtp_pkg::REG_SSRC, $urandom);
		reg_write(h264rtp_pkg::REG_TS_STEP, step);
		reg_write(h264rtp_pkg::REG_MAX_PAYLOAD, mp);
		reg_write(h264rtp_pkg::REG_PAYLOAD_TYPE, $urandom_range(0, 127));
		tx_idle_en = $urandom_range(0, 3) != 0;
		rx_idle_en = $urandom_range(0, 3) != 0;
		cfg_phases++;
	endtask

	initial begin
		int          target, next_cfg, start, pick, body;
		bit          hold_done, pause_done;
		logic [7:0]  hdr;
		logic [19:0] len;
		sb         = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		nal_byte   = '0;
		nal_first  = 1'b0;
		nal_length = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_req   = 1'b0;
		items_done = 0;
		cfg_phases = 1;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Register defaults: stray byte, zero length, SPS and PPS leave the timestamp
		send_byte(8'hFF, 1'b0, 20'hFFFFF);
		send_byte(8'h65, 1'b1, 20'd0);
		send_nal(8'h67, 20'd3, 2);
		send_byte(8'h68, 1'b1, 20'd1);
		wait_idle();

		// Zero max payload acts as one byte per fragment
		reg_write(h264rtp_pkg::REG_SSRC, 32'hFFFF_FFFF);
		reg_write(h264rtp_pkg::REG_TS_STEP, 32'd0);
		reg_write(h264rtp_pkg::REG_MAX_PAYLOAD, 32'd0);
		reg_write(h264rtp_pkg::REG_PAYLOAD_TYPE, 32'd127);
		send_byte(8'hFF, 1'b1, 20'd3);
		send_byte(8'hAA, 1'b0, 20'd0);
		send_byte(8'h00, 1'b0, 20'd0);
		send_byte(8'h00, 1'b1, 20'd0);
		// maximum declared length, cut short by the next NAL
		send_nal(8'h7C, 20'hFFFFF, 2);
		send_nal(8'h41, 20'd2, 1);
		wait_idle();

		// Fragment size changed halfway through a fragmented NAL
		reg_write(h264rtp_pkg::REG_SSRC, 32'd0);
		reg_write(h264rtp_pkg::REG_TS_STEP, 32'hFFFF);
		reg_write(h264rtp_pkg::REG_MAX_PAYLOAD, 32'd3);
		reg_write(h264rtp_pkg::REG_PAYLOAD_TYPE, 32'd0);
		send_nal(8'h5C, 20'd8, 2);
		wait_idle();
		reg_write(h264rtp_pkg::REG_MAX_PAYLOAD, 32'd2);
		repeat (5)
			send_byte(8'($urandom_range(0, 255)), 1'b0,
				LEN_BITS'($urandom_range(0, 20'hFFFFF)));
		wait_idle();
		reg_write(h264rtp_pkg::REG_MAX_PAYLOAD, 32'd4095);
		send_nal(8'h21, 20'd5, 4);

		// Random NALs: mostly whole, some cut short, stray bytes between
		start    = items_done;
		target   = items_done + RAND_ITEMS;
		next_cfg = items_done;
		while (items_done < target) begin
			if (items_done >= next_cfg) begin
				wait_idle();
				random_config();
				next_cfg = items_done + $urandom_range(30, 50);
			end
			if (!hold_done && items_done >= start + 70) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && items_done >= start + 140) begin
				wait_idle();
				pause_done = 1'b1;
			end
			pick = $urandom_range(0, 19);
			hdr  = 8'($urandom_range(0, 255));
			if (pick == 0)
				hdr[4:0] = h264rtp_pkg::NAL_TYPE_SPS;
			else if (pick == 1)
				hdr[4:0] = h264rtp_pkg::NAL_TYPE_PPS;
			if (pick == 2 || pick == 3) begin
				repeat ($urandom_range(1, 2))
					send_byte(8'($urandom_range(0, 255)), 1'b0,
						LEN_BITS'($urandom_range(0, 20'hFFFFF)));
			end else if (pick == 4) begin
				send_nal(hdr, LEN_BITS'($urandom_range(0, 20'hFFFFF)), $urandom_range(0, 5));
			end else if (pick == 5) begin
				len  = 20'($urandom_range(2, 40));
				body = $urandom_range(0, len - 2);
				send_nal(hdr, len, body);
			end else if (pick == 6) begin
				send_nal(hdr, 20'd0, 0);
			end else begin
				len = 20'($urandom_range(1, 40));
				send_nal(hdr, len, int'(len) - 1);
			end
		end
		wait_idle();

		// Flat out, no idling on either side
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		reg_write(h264rtp_pkg::REG_SSRC, $urandom);
		reg_write(h264rtp_pkg::REG_TS_STEP, 32'hFFFF);
		reg_write(h264rtp_pkg::REG_MAX_PAYLOAD, $urandom_range(1, 4095));
		reg_write(h264rtp_pkg::REG_PAYLOAD_TYPE, $urandom_range(0, 127));
		cfg_phases++;
		target = items_done + FLAT_ITEMS;
		while (items_done < target) begin
			hdr = 8'($urandom_range(0, 255));
			len = 20'($urandom_range(1, 8));
			send_nal(hdr, len, int'(len) - 1);
		end
		wait_idle();

		$display("Run: %0d NAL bytes in, %0d RTP bytes checked, %0d packets, %0d FU-A fragments,",
			items_done, sb.checked, sb.packets, sb.fragments);
		$display("  %0d stray bytes, %0d register settings, long hold-off, drain pause, no-idle tail.",
			sb.stray, cfg_phases);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
